// ===== design/tdpt_pkg.sv =====
// Shared constants for the trial-division primality tester.
package tdpt_pkg;

  localparam int DEF_VALUE_WIDTH = 32;

  // First candidate of the 6k-1 / 6k+1 wheel and the wheel step
  localparam int WHEEL_FIRST = 5;
  localparam int WHEEL_STEP  = 6;
  localparam int PAIR_GAP    = 2;

endpackage

// ===== design/trial_division_primality_test.sv =====
// Negative, 0..3 and even words get their verdict from the screen alone;
// other words go to the divider for remainders: one by 3, then up to two
// per wheel pair until one is zero or d > v/d.
// Throughput: one word at a time, through the single bit-serial divider;
// the next word is taken once the last verdict has left the sequencer.
// Reset: synchronous, active high; clears the sequencer and out_valid.
module trial_division_primality_test import tdpt_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_prime_flag
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCREEN = 3'd1;
  localparam logic [2:0] ST_DIV3   = 3'd2;
  localparam logic [2:0] ST_DIVA   = 3'd3;
  localparam logic [2:0] ST_DIVB   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [VALUE_WIDTH-1:0] v;          // word under test
  logic [VALUE_WIDTH-1:0] d;          // current 6k-1 candidate
  logic [VALUE_WIDTH-1:0] d_next;
  logic                   res;        // verdict held until the output frees
  logic                   res_next;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_divisor;
  logic                   div_busy;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [VALUE_WIDTH-1:0] div_rem;
  logic                   rem_zero;
  logic                   out_free;

  assign in_ready = (state == ST_IDLE);
  assign rem_zero = (div_rem == '0);
  // the result register may take a new verdict once the old one is gone
  assign out_free = !out_valid || out_ready;

  tdpt_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (v),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    state_next  = state;
    d_next      = d;
    res_next    = res;
    div_start   = 1'b0;
    div_divisor = VALUE_WIDTH'(3);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCREEN;
        end
      end
      ST_SCREEN: begin
        // settle the trivial cases without the divider
        priority if (v[VALUE_WIDTH-1]) begin
          res_next   = 1'b0;
          state_next = ST_DONE;
        end else if (v <= VALUE_WIDTH'(1)) begin
          res_next   = 1'b0;
          state_next = ST_DONE;
        end else if (v <= VALUE_WIDTH'(3)) begin
          res_next   = 1'b1;
          state_next = ST_DONE;
        end else if (!v[0]) begin
          res_next   = 1'b0;
          state_next = ST_DONE;
        end else begin
          div_start   = 1'b1;
          div_divisor = VALUE_WIDTH'(3);
          state_next  = ST_DIV3;
        end
      end
      ST_DIV3: begin
        if (div_done) begin
          if (rem_zero) begin
            res_next   = 1'b0;
            state_next = ST_DONE;
          end else begin
            d_next      = VALUE_WIDTH'(WHEEL_FIRST);
            div_start   = 1'b1;
            div_divisor = VALUE_WIDTH'(WHEEL_FIRST);
            state_next  = ST_DIVA;
          end
        end
      end
      ST_DIVA: begin
        if (div_done) begin
          // d > v/d means d*d > v: no divisor left to try
          priority if (d > div_quot) begin
            res_next   = 1'b1;
            state_next = ST_DONE;
          end else if (rem_zero) begin
            res_next   = 1'b0;
            state_next = ST_DONE;
          end else begin
            div_start   = 1'b1;
            div_divisor = d + VALUE_WIDTH'(PAIR_GAP);
            state_next  = ST_DIVB;
          end
        end
      end
      ST_DIVB: begin
        if (div_done) begin
          if (rem_zero) begin
            res_next   = 1'b0;
            state_next = ST_DONE;
          end else begin
            // advance the wheel to the next pair
            d_next      = d + VALUE_WIDTH'(WHEEL_STEP);
            div_start   = 1'b1;
            div_divisor = d + VALUE_WIDTH'(WHEEL_STEP);
            state_next  = ST_DIVA;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      v <= value;
    end
    d   <= d_next;
    res <= res_next;
    if (state == ST_DONE && out_free) begin
      is_prime_flag <= res;
    end
  end

  // The divider only runs while the sequencer waits on it
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == ST_DIV3 || state == ST_DIVA || state == ST_DIVB))
    else $error("divider busy outside a division state");

  // A division never starts while another is still running
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("division started while divider busy");

  // An accepted word is screened in the next cycle
  a_screen: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SCREEN))
    else $error("accepted word not screened");

  // A released verdict always shows on the output
  a_release: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("verdict not presented");

endmodule

// ===== design/tdpt_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module tdpt_div import tdpt_pkg::*; #(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   busy,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quot,
  output logic [VALUE_WIDTH-1:0] rem
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] dvd;
  logic [VALUE_WIDTH-1:0] dsr;
  logic [CNT_W-1:0]       cnt;
  logic [VALUE_WIDTH:0]   rem_sh;
  logic [VALUE_WIDTH:0]   diff;

  // shift the next dividend bit into the partial remainder and trial-subtract
  assign rem_sh = {rem, dvd[VALUE_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      dvd <= {dvd[VALUE_WIDTH-2:0], 1'b0};
      if (!diff[VALUE_WIDTH]) begin
        // no borrow: keep the difference
        rem  <= diff[VALUE_WIDTH-1:0];
        quot <= {quot[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[VALUE_WIDTH-1:0];
        quot <= {quot[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== dv/trial_division_primality_test_tb.sv =====
// Self-checking testbench for the trial-division primality tester.
`timescale 1ns / 100ps

module trial_division_primality_test_tb;
  import tdpt_pkg::*;

  localparam int W = DEF_VALUE_WIDTH;

  // Generous wall for the whole run: the largest positive prime alone walks
  // about 7700 wheel pairs.
  localparam longint RUN_LIMIT_NS = 64'd60_000_000;

  // One word waiting to go in; hold_back makes the sender wait for an
  // empty pipe first.
  typedef struct {
    logic signed [W-1:0] value;
    bit                  hold_back;
  } word_t;

  // Verdict owed by the block for a word it has taken.
  typedef struct {
    logic signed [W-1:0] value;
    bit                  prime;
  } verdict_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic signed [W-1:0] value     = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                is_prime_flag;

  word_t    pending_words[$];
  verdict_t verdicts_due[$];

  int errors        = 0;
  int verdicts_seen = 0;
  int primes_seen   = 0;
  int negatives_fed = 0;

  // Sender and receiver pacing
  int word_gap   = 0;
  int tx_quiet   = 0;
  int rx_stall   = 0;
  int rx_quiet   = 0;

  trial_division_primality_test #(
    .VALUE_WIDTH (W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_prime_flag (is_prime_flag)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Primality by the 6k-1 / 6k+1 wheel. The bound d*d <= n is taken as
  // d <= n/d so it stays exact right up to the largest positive value.
  function automatic bit is_prime_word(input logic signed [W-1:0] v);
    logic [63:0] n;
    logic [63:0] d;
    n = '0;
    n[W-1:0] = v;
    if (v[W-1]) return 1'b0;
    if (n <= 1) return 1'b0;
    if (n <= 3) return 1'b1;
    if (n % 2 == 0 || n % 3 == 0) return 1'b0;
    for (d = 64'(WHEEL_FIRST); d <= n / d; d += 64'(WHEEL_STEP)) begin
      if (n % d == 0 || n % (d + 64'(PAIR_GAP)) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Random word. Keep primes small so the wheel walk stays short; large
  // words are negative, even, or carry a small odd factor so the block
  // rejects them after a handful of pairs.
  function automatic logic signed [W-1:0] draw_word();
    int unsigned         small_odd[10] = '{5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    int unsigned         p;
    int unsigned         k;
    logic signed [W-1:0] v;
    int                  kind;
    kind = $urandom_range(0, 99);
    v = $urandom;
    if (kind < 45) begin
      v = $urandom_range(0, 60000);
    end else if (kind < 60) begin
      v = $urandom_range(0, 200);
    end else if (kind < 75) begin
      v[W-1] = 1'b1;
    end else if (kind < 85) begin
      v[W-1] = 1'b0;
      v[0]   = 1'b0;
    end else begin
      p = small_odd[$urandom_range(0, 9)];
      k = $urandom_range(1, 32'h7FFF_FFFF / p);
      v = p * k;
    end
    return v;
  endfunction

  task automatic queue_word(input logic signed [W-1:0] v, input bit hold_back);
    word_t w;
    w.value     = v;
    w.hold_back = hold_back;
    pending_words.push_back(w);
  endtask

  // Sender: take the next word from the queue, honour gaps, and on a
  // hold_back word wait until every verdict owed has come back.
  always @(posedge clk) begin
    verdict_t due;
    if (rst) begin
      in_valid <= 1'b0;
      value    <= '0;
      word_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        due.value = value;
        due.prime = is_prime_word(value);
        verdicts_due.push_back(due);
        if (value[W-1]) negatives_fed++;
      end
      if (!in_valid || in_ready) begin
        if (word_gap > 0) begin
          word_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].hold_back && verdicts_due.size() != 0)) begin
          in_valid <= 1'b1;
          value    <= pending_words[0].value;
          pending_words.pop_front();
          if (tx_quiet > 0) begin
            tx_quiet--;
            word_gap = 0;
          end else begin
            if ($urandom_range(0, 14) == 0) tx_quiet = $urandom_range(5, 15);
            word_gap = idle_len();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random, then check each verdict against the oldest
  // one owed.
  always @(posedge clk) begin
    verdict_t due;
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall = 0;
      rx_quiet = 0;
    end else begin
      if (out_valid && out_ready) begin
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
          $error("is_prime_flag: verdict %0b with no word outstanding", is_prime_flag);
          errors++;
        end else begin
          due = verdicts_due.pop_front();
          if (is_prime_flag !== due.prime) begin
            $error("is_prime_flag for value %0d: expected %0b, actual %0b",
                   due.value, due.prime, is_prime_flag);
            errors++;
          end
          if (due.prime) primes_seen++;
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else if (rx_quiet > 0) begin
        rx_quiet--;
        out_ready <= 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            rx_quiet = $urandom_range(20, 100);
            out_ready <= 1'b1;
          end
          1, 2, 3: begin
            rx_stall = idle_len();
            out_ready <= 1'b0;
          end
          default: out_ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    // Directed words: bounds of the field, the small primes, squares and
    // products of wheel candidates, and words the early checks reject.
    queue_word(0, 1'b0);
    queue_word(1, 1'b0);
    queue_word(2, 1'b0);
    queue_word(3, 1'b0);
    queue_word(4, 1'b0);
    queue_word(5, 1'b0);
    queue_word(6, 1'b0);
    queue_word(7, 1'b0);
    queue_word(9, 1'b0);
    queue_word(25, 1'b0);          // square of the first candidate
    queue_word(29, 1'b0);
    queue_word(35, 1'b0);          // caught by the first of a pair
    queue_word(49, 1'b0);
    queue_word(121, 1'b0);
    queue_word(143, 1'b0);
    queue_word(169, 1'b0);
    queue_word(-1, 1'b0);          // all ones
    queue_word(-2, 1'b0);
    queue_word(32'sh8000_0000, 1'b0); // most negative
    queue_word(32'sh7FFF_FFFE, 1'b0);
    queue_word(32'sh7FFF_FFFD, 1'b0);
    queue_word(65537, 1'b0);
    queue_word(1000003, 1'b0);
    queue_word(32'sh7FFF_FFFF, 1'b0); // largest positive, full wheel walk

    // Random words; drain the pipe before the first and every thirtieth.
    for (int i = 0; i < 76; i++) begin
      queue_word(draw_word(), (i % 30) == 0);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for the sender to run dry and every verdict to come back.
    while (pending_words.size() != 0 || in_valid || verdicts_due.size() != 0)
      @(posedge clk);
    // Allow for a stray verdict to show up.
    repeat (50) @(posedge clk);

    $display("Checked %0d verdicts: %0d prime, %0d negative words, plus field extremes",
             verdicts_seen, primes_seen, negatives_fed);
    $display("and a full wheel walk on the largest positive value.");
    if (errors == 0) begin
      $display("trial_division_primality_test: match");
    end else begin
      $display("trial_division_primality_test: mismatch");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d verdicts still owed", verdicts_due.size());
    $display("trial_division_primality_test: mismatch");
    $finish;
  end

endmodule
